[src/level_set_property_blend_defines.svh]
// Assertion macros shared by the level-set property blend RTL.
`ifndef LEVEL_SET_PROPERTY_BLEND_DEFINES_SVH
`define LEVEL_SET_PROPERTY_BLEND_DEFINES_SVH
`ifndef SYNTHESIS
`define LSP_ASSERT(name, prop) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("lsp assertion failed");
`define LSP_ASSERT_ALWAYS(name, prop) \
  name: assert property (@(posedge clk_i) prop) \
    else $error("lsp assertion failed");
`else
`define LSP_ASSERT(name, prop)
`define LSP_ASSERT_ALWAYS(name, prop)
`endif
`endif

[src/lsp_pkg.sv]
// Types and constants of the level-set property blend.
`default_nettype none
package lsp_pkg;
  localparam int unsigned DivW   = 36;
  localparam int unsigned RemW   = 37;
  localparam int unsigned QuotW  = 31;
  localparam int unsigned DivSteps = 31;
  localparam int unsigned PropW  = 48;
  localparam int unsigned HalfW  = 24;

  localparam logic [31:0] OneQ30 = 32'h4000_0000;
  localparam logic [31:0] OneQ31 = 32'h8000_0000;

  // sin(pi*u)/pi series coefficients, Q1.30
  localparam logic [30:0] SinCoef [7] = '{
    31'd1073741824, 31'd1766234505, 31'd871601792, 31'd204818212,
    31'd28076038, 31'd2519085, 31'd159374
  };

  typedef enum logic [1:0] {
    RegDensIn  = 2'd0,
    RegViscIn  = 2'd1,
    RegDensOut = 2'd2,
    RegViscOut = 2'd3
  } reg_idx_e;

  typedef struct packed {
    logic neg;
    logic inband;
  } lsp_side_t;
endpackage
`default_nettype wire

[src/lsp_div.sv]
// Pipelined restoring divider: floor(num * 2^30 / den) for num <= den.
`default_nettype none
`include "level_set_property_blend_defines.svh"
module lsp_div (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   en_i,
  input  wire logic                   valid_i,
  input  wire logic [35:0]            num_i,
  input  wire logic [35:0]            den_i,
  input  wire lsp_pkg::lsp_side_t     side_i,
  output logic                        valid_o,
  output logic [30:0]                 quot_o,
  output lsp_pkg::lsp_side_t          side_o
);
  import lsp_pkg::*;

  logic              valid_q [DivSteps];
  logic [RemW-1:0]   rem_q   [DivSteps];
  logic [QuotW-1:0]  quot_q  [DivSteps];
  logic [DivW-1:0]   den_q   [DivSteps];
  lsp_side_t         side_q  [DivSteps];

  for (genvar j = 0; j < DivSteps; j++) begin : g_step
    logic [RemW-1:0]  rem_in;
    logic [QuotW-1:0] quot_in;
    logic [DivW-1:0]  den_in;
    logic [RemW-1:0]  rem_d;
    logic             bit_d;

    if (j == 0) begin : g_first
      assign rem_in  = {1'b0, num_i};
      assign quot_in = '0;
      assign den_in  = den_i;
    end else begin : g_next
      // partial remainder stays below den, so the shift fits in RemW bits
      assign rem_in  = {rem_q[j-1][RemW-2:0], 1'b0};
      assign quot_in = quot_q[j-1];
      assign den_in  = den_q[j-1];
    end

    always_comb begin
      bit_d = (rem_in >= {1'b0, den_in});
      rem_d = bit_d ? (rem_in - {1'b0, den_in}) : rem_in;
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        valid_q[j] <= 1'b0;
      end else if (en_i) begin
        valid_q[j] <= (j == 0) ? valid_i : valid_q[(j == 0) ? 0 : j-1];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[j]  <= rem_d;
        quot_q[j] <= {quot_in[QuotW-2:0], bit_d};
        den_q[j]  <= den_in;
        side_q[j] <= (j == 0) ? side_i : side_q[(j == 0) ? 0 : j-1];
      end
    end
  end

  assign valid_o = valid_q[DivSteps-1];
  assign quot_o  = quot_q[DivSteps-1];
  assign side_o  = side_q[DivSteps-1];

  `LSP_ASSERT(a_quot_range, valid_o && side_o.inband |-> quot_o <= OneQ30[30:0])
  `LSP_ASSERT(a_stall_hold, !en_i |=> $stable(valid_o))
  `LSP_ASSERT_ALWAYS(a_rst_empty, !rst_ni |=> !valid_o)
endmodule
`default_nettype wire

[src/level_set_property_blend.sv]
// Top level: smoothed Heaviside blend of two fluid phase properties.
//   channel | dir | fields (low bit up)
//   s_axis  | in  | level_distance[31:0], cell_size_x, cell_size_y, cell_size_z
//   m_axis  | out | mixed_density[47:0], mixed_viscosity[95:48]
//   cfg     | in  | index 0..3: density/viscosity inside, density/viscosity outside
// One beat per cycle sustained while m_axis_tready allows; the path runs through the 31-stage divider,
// the 8 series multiply stages and the split blend multiply.
// Reset clears only valid bits and the property registers.
// A stalled output freezes all stages together; nothing is lost or repeated.
`default_nettype none
`include "level_set_property_blend_defines.svh"
module level_set_property_blend (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         s_axis_tvalid,
  output logic              s_axis_tready,
  // level_distance[31:0], cell_size_x[62:32], cell_size_y[93:63], cell_size_z[124:94]
  input  wire logic [127:0] s_axis_tdata,
  output logic              m_axis_tvalid,
  input  wire logic         m_axis_tready,
  // mixed_density[47:0], mixed_viscosity[95:48]
  output logic [95:0]       m_axis_tdata,
  input  wire logic         cfg_we_i,
  input  wire logic [1:0]   cfg_addr_i,
  input  wire logic [47:0]  cfg_wdata_i
);
  import lsp_pkg::*;

  typedef struct packed {
    lsp_side_t   side;
    logic [30:0] tq;
    logic [29:0] u;
  } poly_t;

  logic [PropW-1:0] w_in_q  [2];
  logic [PropW-1:0] w_out_q [2];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      w_in_q[0]  <= '0;
      w_in_q[1]  <= '0;
      w_out_q[0] <= '0;
      w_out_q[1] <= '0;
    end else if (cfg_we_i) begin
      case (reg_idx_e'(cfg_addr_i))
        RegDensIn:  w_in_q[0]  <= cfg_wdata_i;
        RegViscIn:  w_in_q[1]  <= cfg_wdata_i;
        RegDensOut: w_out_q[0] <= cfg_wdata_i;
        RegViscOut: w_out_q[1] <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  logic en;
  logic o_valid_q;
  assign en = !o_valid_q || m_axis_tready;
  assign s_axis_tready = en;

  // stage A: magnitude and scaled numerator / denominator
  logic        a_valid_q, a_neg_q;
  logic [35:0] a_num_q, a_den_q;
  logic [31:0] phi, mag;
  logic [32:0] sum_s;
  assign phi   = s_axis_tdata[31:0];
  assign mag   = phi[31] ? (~phi + 32'd1) : phi;
  assign sum_s = {2'b0, s_axis_tdata[62:32]} + {2'b0, s_axis_tdata[93:63]}
               + {2'b0, s_axis_tdata[124:94]};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) a_valid_q <= 1'b0;
    else if (en) a_valid_q <= s_axis_tvalid;
  end
  always_ff @(posedge clk_i) begin
    if (en) begin
      a_neg_q <= phi[31];
      a_num_q <= {mag, 4'b0} - {4'b0, mag};
      a_den_q <= {sum_s, 3'b0};
    end
  end

  // stage B: band test
  logic        b_valid_q;
  lsp_side_t   b_side_q;
  logic [35:0] b_num_q, b_den_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) b_valid_q <= 1'b0;
    else if (en) b_valid_q <= a_valid_q;
  end
  always_ff @(posedge clk_i) begin
    if (en) begin
      b_side_q.neg    <= a_neg_q;
      b_side_q.inband <= (a_den_q != '0) && (a_num_q <= a_den_q);
      b_num_q         <= a_num_q;
      b_den_q         <= a_den_q;
    end
  end

  logic        d_valid;
  logic [30:0] d_quot;
  lsp_side_t   d_side;

  lsp_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (b_valid_q),
    .num_i   (b_num_q),
    .den_i   (b_den_q),
    .side_i  (b_side_q),
    .valid_o (d_valid),
    .quot_o  (d_quot),
    .side_o  (d_side)
  );

  // stage U: reflect t about 1/2
  logic  u_valid_q;
  poly_t u_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) u_valid_q <= 1'b0;
    else if (en) u_valid_q <= d_valid;
  end
  always_ff @(posedge clk_i) begin
    if (en) begin
      u_q.side <= d_side;
      u_q.tq   <= d_quot;
      u_q.u    <= (d_quot <= 31'h2000_0000) ? d_quot[29:0]
                                            : 30'(OneQ30[30:0] - d_quot);
    end
  end

  // series stages: 0 squares u, 1..6 are Horner steps
  logic        h_valid_q [7];
  poly_t       h_c_q     [7];
  logic [28:0] h_u2_q    [7];
  logic [30:0] h_p_q     [7];
  logic [59:0] u_sq;
  assign u_sq = u_q.u * u_q.u;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) h_valid_q[0] <= 1'b0;
    else if (en) h_valid_q[0] <= u_valid_q;
  end
  always_ff @(posedge clk_i) begin
    if (en) begin
      h_c_q[0]  <= u_q;
      h_u2_q[0] <= u_sq[58:30];
      h_p_q[0]  <= SinCoef[6];
    end
  end

  for (genvar j = 1; j < 7; j++) begin : g_horner
    logic [59:0] prod;
    logic [29:0] sub;
    logic [30:0] coef;
    assign prod = h_u2_q[j-1] * h_p_q[j-1];
    assign sub  = prod[59:30];
    assign coef = SinCoef[6-j];

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) h_valid_q[j] <= 1'b0;
      else if (en) h_valid_q[j] <= h_valid_q[j-1];
    end
    always_ff @(posedge clk_i) begin
      if (en) begin
        h_c_q[j]  <= h_c_q[j-1];
        h_u2_q[j] <= h_u2_q[j-1];
        h_p_q[j]  <= (coef > {1'b0, sub}) ? (coef - {1'b0, sub}) : '0;
      end
    end
  end

  // stage G: g = u * p
  logic        g_valid_q;
  poly_t       g_c_q;
  logic [30:0] g_q;
  logic [60:0] g_prod;
  assign g_prod = h_c_q[6].u * h_p_q[6];
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) g_valid_q <= 1'b0;
    else if (en) g_valid_q <= h_valid_q[6];
  end
  always_ff @(posedge clk_i) begin
    if (en) begin
      g_c_q <= h_c_q[6];
      g_q   <= g_prod[60:30];
    end
  end

  // stage H: Heaviside weight in Q1.31 and its complement
  logic        hw_valid_q;
  logic [31:0] h31_q, g31_q;
  logic [31:0] m_sum, m_cl, h31_d;
  always_comb begin
    m_sum = {1'b0, g_c_q.tq} + {1'b0, g_q};
    m_cl  = (m_sum > OneQ30) ? OneQ30 : m_sum;
    if (g_c_q.side.inband) h31_d = g_c_q.side.neg ? (OneQ30 - m_cl) : (OneQ30 + m_cl);
    else                   h31_d = g_c_q.side.neg ? '0 : OneQ31;
  end
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) hw_valid_q <= 1'b0;
    else if (en) hw_valid_q <= g_valid_q;
  end
  always_ff @(posedge clk_i) begin
    if (en) begin
      h31_q <= h31_d;
      g31_q <= OneQ31 - h31_d;
    end
  end

  // stage P: split products, stage S: sums, stage O: rounding
  logic        p_valid_q, s_valid_q;
  logic [55:0] pa_in_q [2], pa_out_q [2], pb_in_q [2], pb_out_q [2];
  logic [56:0] sa_q [2], sb_q [2];
  logic [PropW-1:0] o_data_q [2];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p_valid_q <= 1'b0;
      s_valid_q <= 1'b0;
      o_valid_q <= 1'b0;
    end else if (en) begin
      p_valid_q <= hw_valid_q;
      s_valid_q <= p_valid_q;
      o_valid_q <= s_valid_q;
    end
  end

  for (genvar k = 0; k < 2; k++) begin : g_prop
    logic [57:0] low_sum;
    logic [PropW-1:0] low;
    assign low_sum = {27'b0, sa_q[k][6:0], 24'b0} + {1'b0, sb_q[k]} + 58'h4000_0000;
    assign low     = PropW'(low_sum[57:31]);

    always_ff @(posedge clk_i) begin
      if (en) begin
        pa_in_q[k]  <= w_in_q[k][PropW-1:HalfW]  * h31_q;
        pa_out_q[k] <= w_out_q[k][PropW-1:HalfW] * g31_q;
        pb_in_q[k]  <= w_in_q[k][HalfW-1:0]      * h31_q;
        pb_out_q[k] <= w_out_q[k][HalfW-1:0]     * g31_q;
        sa_q[k]     <= {1'b0, pa_in_q[k]} + {1'b0, pa_out_q[k]};
        sb_q[k]     <= {1'b0, pb_in_q[k]} + {1'b0, pb_out_q[k]};
        o_data_q[k] <= PropW'(sa_q[k][56:7]) + low;
      end
    end
  end

  assign m_axis_tvalid = o_valid_q;
  assign m_axis_tdata  = {o_data_q[1], o_data_q[0]};

  `LSP_ASSERT(a_in_to_a, en && s_axis_tvalid |=> a_valid_q)
  `LSP_ASSERT(a_h_range, hw_valid_q |-> h31_q <= OneQ31)
  `LSP_ASSERT(a_h_sum, hw_valid_q |-> (h31_q + g31_q) == OneQ31)
  `LSP_ASSERT(a_out_band, g_valid_q && !g_c_q.side.inband |-> (h31_d == '0 || h31_d == OneQ31))
endmodule
`default_nettype wire
